// ===== rtl/wsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants for the frame receiver: result codes, parser
// phases and the result record that travels from the parser to the output
// register.
// ----------------------------------------------------------------------------
package wsr_pkg;

   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int LENGTH_W  = 64;
   localparam int FIELD_W   = 3;
   localparam int KEY_BYTES = 4;
   localparam int KEY_IDX_W = $clog2(KEY_BYTES);

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ZERO = 2'd2;

   localparam logic [3:0] OPCODE_MASK = 4'hf;
   localparam logic [3:0] OPCODE_TEXT = 4'h1;
   localparam logic [6:0] LEN7_MASK   = 7'h7f;
   localparam logic [6:0] LEN7_EXT16  = 7'd126;
   localparam logic [6:0] LEN7_EXT64  = 7'd127;

   localparam logic [FIELD_W-1:0] EXT16_BYTES = 3'd2;

   typedef enum logic [6:0] {
      PH_HDR0    = 7'b0000001,
      PH_HDR1    = 7'b0000010,
      PH_DROP1   = 7'b0000100,
      PH_EXT16   = 7'b0001000,
      PH_EXT64   = 7'b0010000,
      PH_KEY     = 7'b0100000,
      PH_PAYLOAD = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              fin_bit;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/wsr_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsr channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface wsr_req_if
   import wsr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsr_rsp_if
   import wsr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data;
   logic              last;
   logic              fin_bit;

   modport source (output valid, output kind, output data, output last,
                   output fin_bit, input ready);
   modport sink   (input valid, input kind, input data, input last,
                   input fin_bit, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsr_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsr_in_stage
// Input register: captures one received byte and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module wsr_in_stage
   import wsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_byte,
   input  wire logic              consume,
   output logic                   in_valid,
   output logic [BYTE_W-1:0]      in_byte
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_ready = !valid_ff || consume;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule
`default_nettype wire

// ===== rtl/wsr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsr_parser
// Frame header parser and payload unmasking. Holds the frame state and
// advances it by one byte per consumed transaction.
// ----------------------------------------------------------------------------
module wsr_parser
   import wsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              out_ready,
   output logic                   consume,
   output result_type             result
);

   phase_type                phase_ff, phase_in;
   logic                     fin_ff, fin_in;
   logic                     masked_ff, masked_in;
   logic [LENGTH_W-1:0]      length_ff, length_in;
   logic [FIELD_W-1:0]       field_ff, field_in;
   logic [KEY_IDX_W-1:0]     pidx_ff, pidx_in;
   logic [BYTE_W-1:0]        key_ff [KEY_BYTES];
   logic [BYTE_W-1:0]        key_in [KEY_BYTES];

   logic [LENGTH_W-1:0]      shifted;
   logic [FIELD_W-1:0]       field_inc;
   logic                     length_known;
   logic [LENGTH_W-1:0]      known_length;
   logic                     known_masked;

   assign consume   = in_valid && out_ready;
   assign shifted   = {length_ff[LENGTH_W-BYTE_W-1:0], in_byte};
   assign field_inc = field_ff + FIELD_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      masked_in    = masked_ff;
      length_in    = length_ff;
      field_in     = field_ff;
      pidx_in      = pidx_ff;
      key_in       = key_ff;
      result       = '0;
      length_known = 1'b0;
      known_length = '0;
      known_masked = masked_ff;

      unique case (phase_ff)
         PH_HDR1: begin
            masked_in    = in_byte[7];
            known_masked = in_byte[7];
            field_in     = '0;
            length_in    = '0;
            if ((in_byte[6:0] & LEN7_MASK) == LEN7_EXT16) begin
               phase_in = PH_EXT16;
            end else if ((in_byte[6:0] & LEN7_MASK) == LEN7_EXT64) begin
               phase_in = PH_EXT64;
            end else begin
               length_in    = LENGTH_W'(in_byte[6:0]);
               known_length = LENGTH_W'(in_byte[6:0]);
               length_known = 1'b1;
            end
         end
         PH_DROP1: begin
            phase_in       = PH_HDR0;
            result.valid   = 1'b1;
            result.kind    = KIND_DROP;
            result.fin_bit = fin_ff;
         end
         PH_EXT16, PH_EXT64: begin
            length_in = shifted;
            field_in  = field_inc;
            if ((phase_ff == PH_EXT16 && field_inc == EXT16_BYTES) ||
                (phase_ff == PH_EXT64 && field_inc == '0)) begin
               known_length = shifted;
               length_known = 1'b1;
            end
         end
         PH_KEY: begin
            key_in[field_ff[KEY_IDX_W-1:0]] = in_byte;
            field_in = field_inc;
            if (field_inc[KEY_IDX_W]) begin
               field_in = '0;
               pidx_in  = '0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.valid   = 1'b1;
            result.kind    = KIND_DATA;
            result.data    = masked_ff ? (in_byte ^ key_ff[pidx_ff]) : in_byte;
            result.last    = (length_ff == LENGTH_W'(1));
            result.fin_bit = fin_ff;
            pidx_in        = pidx_ff + KEY_IDX_W'(1);
            length_in      = length_ff - LENGTH_W'(1);
            if (result.last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            fin_in   = in_byte[7];
            phase_in = ((in_byte[3:0] & OPCODE_MASK) == OPCODE_TEXT) ? PH_HDR1 : PH_DROP1;
         end
      endcase

      if (length_known) begin
         if (known_length == '0) begin
            phase_in       = PH_HDR0;
            result.valid   = 1'b1;
            result.kind    = KIND_ZERO;
            result.fin_bit = fin_ff;
         end else begin
            field_in = '0;
            pidx_in  = '0;
            phase_in = known_masked ? PH_KEY : PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         length_ff <= '0;
         field_ff  <= '0;
         pidx_ff   <= '0;
         key_ff    <= '{default: '0};
      end else if (consume) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         length_ff <= length_in;
         field_ff  <= field_in;
         pidx_ff   <= pidx_in;
         key_ff    <= key_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wsr_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsr_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module wsr_out_stage
   import wsr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   input  wire logic       load,
   output logic            out_ready,
   wsr_rsp_if.source       rsp_ch
);

   logic       valid_ff, valid_in;
   result_type hold_ff, hold_in;

   assign out_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      hold_in  = hold_ff;
      if (out_ready) begin
         valid_in = load && result.valid;
         hold_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hold_ff <= hold_in;
   end

   assign rsp_ch.valid   = valid_ff;
   assign rsp_ch.kind    = hold_ff.kind;
   assign rsp_ch.data    = hold_ff.data;
   assign rsp_ch.last    = hold_ff.last;
   assign rsp_ch.fin_bit = hold_ff.fin_bit;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core
// Byte-serial deframer for masked and unmasked text frames.
//
//   channel   direction  payload
//   req_ch    in         rx_byte
//   rsp_ch    out        kind, data, last, fin_bit
//
// One byte per cycle sustained while rsp_ch does not stall; an accepted byte
// goes into the input register, then through the parser into the result
// register, where its result becomes valid.
// Header, length and key bytes give no result unless a drop or zero-length
// report is due. Reset is synchronous and returns the parser to the first
// header byte. A stall on rsp_ch holds the parser state and the input
// register; req_ch.ready falls once both are full.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_core
   import wsr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wsr_req_if.sink   req_ch,
   wsr_rsp_if.source rsp_ch
);

   logic              consume;
   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              out_ready;
   result_type        result;

   wsr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_byte  (req_ch.rx_byte),
      .consume   (consume),
      .in_valid  (in_valid),
      .in_byte   (in_byte)
   );

   wsr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .out_ready (out_ready),
      .consume   (consume),
      .result    (result)
   );

   wsr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .load      (consume),
      .out_ready (out_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== tb/websocket_frame_receiver_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core_test
// Feeds byte streams of text, control and malformed frames into the
// deframer and checks every result against a byte-serial frame parser
// kept in the scoreboard. Stimulus is bursty, the result side stalls on
// shifting patterns and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_core_test;
   import wsr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int STREAM_BYTES = 1400;
   localparam int HOLD_START   = 600;
   localparam int HOLD_CYCLES  = 400;

   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} length_form_type;
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_RARE_STALL, SINK_PERIODIC} sink_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              fin_bit;
   } frame_result_type;

   class frame_scoreboard;
      phase_type            phase;
      logic                 fin_flag;
      logic                 masked_flag;
      logic [LENGTH_W-1:0]  frame_length;
      logic [LENGTH_W-1:0]  byte_counter;
      logic [FIELD_W-1:0]   field_idx;
      logic [BYTE_W-1:0]    mask_key [KEY_BYTES];
      frame_result_type     pending [$];
      int                   mismatches;

      function new();
         phase        = PH_HDR0;
         fin_flag     = 1'b0;
         masked_flag  = 1'b0;
         frame_length = '0;
         byte_counter = '0;
         field_idx    = '0;
         foreach (mask_key[i]) mask_key[i] = '0;
         mismatches   = 0;
      endfunction

      function void push_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                logic last);
         frame_result_type r;
         r.kind    = kind;
         r.data    = data;
         r.last    = last;
         r.fin_bit = fin_flag;
         pending.push_back(r);
      endfunction

      function void close_length();
         if (frame_length == '0) begin
            phase = PH_HDR0;
            push_result(KIND_ZERO, '0, 1'b0);
         end else begin
            field_idx    = '0;
            byte_counter = '0;
            phase        = masked_flag ? PH_KEY : PH_PAYLOAD;
         end
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         logic [BYTE_W-1:0] d;
         logic              last;
         case (phase)
            PH_HDR1: begin
               masked_flag  = b[7];
               frame_length = '0;
               field_idx    = '0;
               if ((b[6:0] & LEN7_MASK) == LEN7_EXT16) begin
                  phase = PH_EXT16;
               end else if ((b[6:0] & LEN7_MASK) == LEN7_EXT64) begin
                  phase = PH_EXT64;
               end else begin
                  frame_length = LENGTH_W'(b[6:0]);
                  close_length();
               end
            end
            PH_DROP1: begin
               phase = PH_HDR0;
               push_result(KIND_DROP, '0, 1'b0);
            end
            PH_EXT16, PH_EXT64: begin
               frame_length = {frame_length[LENGTH_W-BYTE_W-1:0], b};
               field_idx    = field_idx + 1'b1;
               if ((phase == PH_EXT16 && field_idx == EXT16_BYTES) ||
                   (phase == PH_EXT64 && field_idx == '0))
                  close_length();
            end
            PH_KEY: begin
               mask_key[field_idx[KEY_IDX_W-1:0]] = b;
               field_idx = field_idx + 1'b1;
               if (field_idx >= KEY_BYTES) begin
                  field_idx    = '0;
                  byte_counter = '0;
                  phase        = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               d = masked_flag ? (b ^ mask_key[byte_counter[KEY_IDX_W-1:0]]) : b;
               byte_counter = byte_counter + 1'b1;
               last = (byte_counter == frame_length);
               if (last) phase = PH_HDR0;
               push_result(KIND_DATA, d, last);
            end
            default: begin
               fin_flag = b[7];
               phase = ((b[3:0] & OPCODE_MASK) == OPCODE_TEXT) ? PH_HDR1 : PH_DROP1;
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                        logic last, logic fin_bit);
         frame_result_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction kind=%0d data=%02h",
                                      kind, data));
         end else begin
            want = pending.pop_front();
            if (kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (data !== want.data)
               report_mismatch($sformatf("data %02h, want %02h", data, want.data));
            if (last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            if (fin_bit !== want.fin_bit)
               report_mismatch($sformatf("fin_bit %0b, want %0b", fin_bit, want.fin_bit));
         end
      endtask

      task close_out();
         if (pending.size() != 0)
            report_mismatch($sformatf("%0d expected transactions never arrived",
                                      pending.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsr_req_if req_ch ();
   wsr_rsp_if rsp_ch ();

   websocket_frame_receiver_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #1 clock = ~clock;

   frame_scoreboard   sb = new();
   logic [BYTE_W-1:0] byte_stream [$];
   bit                req_fired = 1'b0;
   int                cycle_count = 0;

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic void add_text_frame(bit fin, logic [2:0] rsv, bit masked,
                                          length_form_type form,
                                          logic [LENGTH_W-1:0] length,
                                          int payload_bytes);
      byte_stream.push_back({fin, rsv, OPCODE_TEXT});
      case (form)
         LEN_SHORT: byte_stream.push_back({masked, length[6:0]});
         LEN_EXT16: begin
            byte_stream.push_back({masked, LEN7_EXT16});
            byte_stream.push_back(length[15:8]);
            byte_stream.push_back(length[7:0]);
         end
         default: begin
            byte_stream.push_back({masked, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) byte_stream.push_back(length[i*8 +: 8]);
         end
      endcase
      if (length == '0) return;
      if (masked) repeat (KEY_BYTES) byte_stream.push_back(rand_byte());
      repeat (payload_bytes) byte_stream.push_back(rand_byte());
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 125;
      if (r < 10) return $urandom_range(40, 124);
      return $urandom_range(1, 24);
   endfunction

   function automatic void build_stream();
      int              r;
      int              len;
      length_form_type form;
      logic [3:0]      opcode;
      // zero length, masked: error before any key byte
      add_text_frame(1'b1, 3'b000, 1'b1, LEN_SHORT, '0, 0);
      // non-text opcodes
      byte_stream.push_back(8'h82);
      byte_stream.push_back(8'hff);
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'h00);
      // fin clear, reserved bits set, unmasked single byte
      add_text_frame(1'b0, 3'b111, 1'b0, LEN_SHORT, LENGTH_W'(1), 1);
      add_text_frame(1'b1, 3'b000, 1'b0, LEN_EXT16, '0, 0);
      add_text_frame(1'b0, 3'b000, 1'b1, LEN_EXT64, '0, 0);
      add_text_frame(1'b1, 3'b010, 1'b1, LEN_SHORT, LENGTH_W'(5), 5);
      add_text_frame(1'b1, 3'b000, 1'b1, LEN_EXT16, LENGTH_W'(3), 3);

      while (byte_stream.size() < STREAM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            do opcode = 4'($urandom); while (opcode == OPCODE_TEXT);
            byte_stream.push_back({rand_byte() & 8'hf0 | 8'(opcode)});
            byte_stream.push_back(rand_byte());
         end else if (r < 18) begin
            form = length_form_type'($urandom_range(0, 2));
            add_text_frame(1'($urandom), 3'($urandom), 1'($urandom), form, '0, 0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               form = LEN_SHORT;
               len  = pick_length();
            end else if (r < 92) begin
               form = LEN_EXT16;
               len  = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 300)
                                                   : $urandom_range(1, 40);
            end else begin
               form = LEN_EXT64;
               len  = $urandom_range(1, 40);
            end
            add_text_frame(1'($urandom), 3'($urandom), 1'($urandom), form,
                           LENGTH_W'(len), len);
         end
      end
      // unsigned 64-bit length with the top bit set; stream ends mid-payload
      add_text_frame(1'b1, 3'b000, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0003, 6);
   endfunction

   task automatic offer_byte(input logic [BYTE_W-1:0] b);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(negedge clock); while (!req_fired);
   endtask

   task automatic drive_stream();
      int burst;
      int gap;
      int idx;
      idx = 0;
      while (idx < byte_stream.size()) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                             : $urandom_range(1, 24);
         gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         repeat (burst) begin
            if (idx < byte_stream.size()) begin
               offer_byte(byte_stream[idx]);
               idx++;
            end
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_ch.valid && req_ch.ready;
         if (req_fired) sb.note_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.kind, rsp_ch.data, rsp_ch.last, rsp_ch.fin_bit);
      end
   end

   initial begin
      sink_mode_type mode;
      int            span;
      int            tick;
      logic          open;
      mode = SINK_OPEN;
      span = 0;
      tick = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         tick++;
         if (span == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
         end
         span--;
         if (tick >= HOLD_START && tick < HOLD_START + HOLD_CYCLES) begin
            open = 1'b0;
         end else begin
            case (mode)
               SINK_OPEN:       open = 1'b1;
               SINK_COIN:       open = 1'($urandom);
               SINK_RARE_STALL: open = ($urandom_range(0, 7) != 0);
               default:         open = ((tick % 5) < 2);
            endcase
         end
         rsp_ch.ready <= open;
         @(negedge clock);
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      build_stream();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      drive_stream();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
